// ----- design/fbsm_pkg.sv -----
// Package: shared widths, command codes and control structs for the frame buffer swap manager.
package fbsm_pkg;

    localparam int ID_W            = 2;
    localparam int CMD_W           = 3;
    localparam int PEND_DEPTH      = 2;
    localparam int PUSH_SLOTS      = 4;
    localparam int NUM_BUFFERS_DEF = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLAIM   = 3'd0,
        CMD_PRESENT = 3'd1,
        CMD_GET     = 3'd2,
        CMD_BLANK   = 3'd3,
        CMD_VSYNC   = 3'd4,
        CMD_ILACE   = 3'd5
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  buffer_id;
        logic             sync;
        logic             release_previous;
        logic             set_black;
        logic             interlace_on;
    } req_word_t;

    typedef struct packed {
        logic [ID_W-1:0] result_id;
        logic            result_valid;
        logic [ID_W-1:0] shown_id;
        logic            shown_valid;
        logic            blanked;
        logic            blank_is_black;
        logic            error;
    } rsp_word_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic push;
        logic finish;
    } ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic push_busy;
    } sts_t;

endpackage

// ----- design/fbsm_if.sv -----
// Interfaces: command channel and response channel with valid/ready handshake.
interface fbsm_req_if;
    logic                       valid;
    logic                       ready;
    logic [fbsm_pkg::CMD_W-1:0] cmd;
    logic [fbsm_pkg::ID_W-1:0]  buffer_id;
    logic                       sync;
    logic                       release_previous;
    logic                       set_black;
    logic                       interlace_on;

    modport source (output valid, cmd, buffer_id, sync, release_previous, set_black,
                    interlace_on, input ready);
    modport sink (input valid, cmd, buffer_id, sync, release_previous, set_black,
                  interlace_on, output ready);
endinterface

interface fbsm_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [fbsm_pkg::ID_W-1:0] result_id;
    logic                      result_valid;
    logic [fbsm_pkg::ID_W-1:0] shown_id;
    logic                      shown_valid;
    logic                      blanked;
    logic                      blank_is_black;
    logic                      error;

    modport source (output valid, result_id, result_valid, shown_id, shown_valid, blanked,
                    blank_is_black, error, input ready);
    modport sink (input valid, result_id, result_valid, shown_id, shown_valid, blanked,
                  blank_is_black, error, output ready);
endinterface

// ----- design/fbsm_ctrl.sv -----
// Controller: sequences accept, execute, free-list drain and response load.
module fbsm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  fbsm_pkg::sts_t  sts,
    output fbsm_pkg::ctl_t  ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DRAIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        ctl.load   = (state_reg == S_IDLE) && in_valid;
        ctl.exec   = (state_reg == S_EXEC);
        ctl.push   = (state_reg == S_DRAIN) && sts.push_busy;
        ctl.finish = (state_reg == S_DRAIN) && !sts.push_busy
                     && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (ctl.finish)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- design/fbsm_dp.sv -----
// Datapath: free list, pending queue, current/last buffers, flags and push queue.
module fbsm_dp #(
    parameter int NUM_BUFFERS = fbsm_pkg::NUM_BUFFERS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fbsm_pkg::req_word_t req_word,
    input  fbsm_pkg::ctl_t      ctl,
    output fbsm_pkg::sts_t      sts,
    output fbsm_pkg::rsp_word_t rsp_word
);

    localparam int ID_W  = fbsm_pkg::ID_W;
    localparam int PQ_N  = fbsm_pkg::PUSH_SLOTS;
    localparam int PD    = fbsm_pkg::PEND_DEPTH;
    localparam int CNT_W = $clog2(NUM_BUFFERS + 1);
    localparam int IDX_W = $clog2(NUM_BUFFERS);

    // control state
    logic [ID_W-1:0]  free_reg [NUM_BUFFERS];
    logic [ID_W-1:0]  free_next [NUM_BUFFERS];
    logic [CNT_W-1:0] fc_reg, fc_next;
    logic [1:0]       pc_reg, pc_next;
    logic [ID_W-1:0]  cur_reg, cur_next;
    logic             cv_reg, cv_next;
    logic [ID_W-1:0]  last_reg, last_next;
    logic             lv_reg, lv_next;
    logic             blank_reg, blank_next;
    logic             black_reg, black_next;
    logic             il_reg, il_next;
    logic             skip_reg, skip_next;
    logic             err_reg, err_next;
    logic [PQ_N-1:0]  pqv_reg, pqv_next;

    // payload
    logic [ID_W-1:0]     pend_reg [PD];
    logic [ID_W-1:0]     pend_next [PD];
    logic [ID_W-1:0]     pq_reg [PQ_N];
    logic [ID_W-1:0]     pq_next [PQ_N];
    logic [ID_W-1:0]     res_id_reg, res_id_next;
    logic                res_v_reg, res_v_next;
    fbsm_pkg::req_word_t req_reg;
    fbsm_pkg::rsp_word_t out_reg, out_next;

    fbsm_pkg::cmd_t  cmd;
    logic [1:0]      sel;
    logic [ID_W-1:0] push_id;

    assign cmd = fbsm_pkg::cmd_t'(req_reg.cmd);

    // lowest pending push slot first
    always_comb
    begin
        sel = 2'd0;
        for (int k = PQ_N - 1; k >= 0; k--)
        begin
            if (pqv_reg[k])
            begin
                sel = 2'(k);
            end
        end
        push_id = pq_reg[sel];
    end

    always_comb
    begin
        free_next  = free_reg;
        fc_next    = fc_reg;
        pc_next    = pc_reg;
        cur_next   = cur_reg;
        cv_next    = cv_reg;
        last_next  = last_reg;
        lv_next    = lv_reg;
        blank_next = blank_reg;
        black_next = black_reg;
        il_next    = il_reg;
        skip_next  = skip_reg;
        err_next   = err_reg;
        pqv_next   = pqv_reg;
        pend_next  = pend_reg;
        pq_next    = pq_reg;
        res_id_next = res_id_reg;
        res_v_next  = res_v_reg;

        if (ctl.exec)
        begin
            err_next    = 1'b0;
            pqv_next    = '0;
            res_id_next = '0;
            res_v_next  = 1'b0;
            case (cmd)
                fbsm_pkg::CMD_CLAIM:
                begin
                    if (fc_reg != '0)
                    begin
                        res_id_next = free_reg[0];
                        res_v_next  = 1'b1;
                        fc_next     = fc_reg - CNT_W'(1);
                        for (int i = 0; i < NUM_BUFFERS - 1; i++)
                        begin
                            free_next[i] = free_reg[i+1];
                        end
                    end
                    else if (lv_reg)
                    begin
                        res_id_next = last_reg;
                        res_v_next  = 1'b1;
                        lv_next     = 1'b0;
                    end
                    else if (cv_reg)
                    begin
                        res_id_next = cur_reg;
                        res_v_next  = 1'b1;
                        if (pc_reg != 2'd0)
                        begin
                            cur_next     = pend_reg[0];
                            pend_next[0] = pend_reg[1];
                            pc_next      = pc_reg - 2'd1;
                        end
                        else
                        begin
                            cv_next = 1'b0;
                        end
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                fbsm_pkg::CMD_PRESENT:
                begin
                    if (CNT_W'(req_reg.buffer_id) >= CNT_W'(NUM_BUFFERS))
                    begin
                        err_next = 1'b1;
                    end
                    else if (req_reg.sync && !blank_reg)
                    begin
                        if (pc_reg < 2'(PD))
                        begin
                            pend_next[pc_reg[0]] = req_reg.buffer_id;
                            pc_next              = pc_reg + 2'd1;
                        end
                        else if (il_reg)
                        begin
                            pq_next[0]   = pend_reg[0];
                            pq_next[1]   = pend_reg[1];
                            pqv_next     = 4'b0011;
                            pend_next[0] = req_reg.buffer_id;
                            pc_next      = 2'd1;
                        end
                        else
                        begin
                            pq_next[0]   = pend_reg[0];
                            pqv_next     = 4'b0001;
                            pend_next[0] = pend_reg[1];
                            pend_next[1] = req_reg.buffer_id;
                        end
                    end
                    else
                    begin
                        pq_next[0]  = pend_reg[0];
                        pq_next[1]  = pend_reg[1];
                        pq_next[2]  = last_reg;
                        pq_next[3]  = cur_reg;
                        pqv_next    = {cv_reg && req_reg.release_previous, lv_reg,
                                       pc_reg == 2'd2, pc_reg != 2'd0};
                        lv_next     = 1'b0;
                        cur_next    = req_reg.buffer_id;
                        cv_next     = 1'b1;
                        pc_next     = 2'd0;
                        blank_next  = 1'b0;
                    end
                end
                fbsm_pkg::CMD_GET:
                begin
                    if (pc_reg != 2'd0)
                    begin
                        pq_next[0]  = cur_reg;
                        pq_next[1]  = pend_reg[0];
                        pqv_next    = {2'b00, pc_reg == 2'd2, cv_reg};
                        cur_next    = (pc_reg == 2'd2) ? pend_reg[1] : pend_reg[0];
                        cv_next     = 1'b1;
                        pc_next     = 2'd0;
                        res_id_next = (pc_reg == 2'd2) ? pend_reg[1] : pend_reg[0];
                        res_v_next  = 1'b1;
                    end
                    else
                    begin
                        res_id_next = cv_reg ? cur_reg : '0;
                        res_v_next  = cv_reg;
                    end
                end
                fbsm_pkg::CMD_BLANK:
                begin
                    blank_next = 1'b1;
                    black_next = req_reg.set_black;
                    pq_next[0] = pend_reg[0];
                    pq_next[1] = pend_reg[1];
                    pq_next[2] = last_reg;
                    pq_next[3] = cur_reg;
                    pqv_next   = {cv_reg, lv_reg, pc_reg == 2'd2, pc_reg != 2'd0};
                    lv_next    = 1'b0;
                    cv_next    = 1'b0;
                    pc_next    = 2'd0;
                end
                fbsm_pkg::CMD_VSYNC:
                begin
                    if (!blank_reg)
                    begin
                        if (pc_reg != 2'd0)
                        begin
                            if (!il_reg || skip_reg)
                            begin
                                if (!il_reg)
                                begin
                                    pq_next[0] = cur_reg;
                                    pqv_next   = {3'b000, cv_reg};
                                end
                                else
                                begin
                                    // skip phase: old last goes back, current may become last
                                    pq_next[2] = last_reg;
                                    pq_next[3] = cur_reg;
                                    pqv_next   = {(pc_reg == 2'd2) && cv_reg, lv_reg, 2'b00};
                                    if (pc_reg == 2'd2)
                                    begin
                                        lv_next = 1'b0;
                                    end
                                    else
                                    begin
                                        last_next = cur_reg;
                                        lv_next   = cv_reg;
                                    end
                                end
                                cur_next     = pend_reg[0];
                                cv_next      = 1'b1;
                                pend_next[0] = pend_reg[1];
                                pc_next      = pc_reg - 2'd1;
                            end
                            else
                            begin
                                if (pc_reg == 2'd2)
                                begin
                                    pq_next[2] = last_reg;
                                    pq_next[3] = cur_reg;
                                    pqv_next   = {cv_reg, lv_reg, 2'b00};
                                    cur_next   = pend_reg[1];
                                    cv_next    = 1'b1;
                                    last_next  = pend_reg[0];
                                    lv_next    = 1'b1;
                                    pc_next    = 2'd0;
                                end
                                else if (lv_reg)
                                begin
                                    cur_next  = last_reg;
                                    cv_next   = lv_reg;
                                    last_next = cur_reg;
                                    lv_next   = cv_reg;
                                end
                                skip_next = !skip_reg;
                            end
                        end
                        else if (il_reg)
                        begin
                            if (lv_reg)
                            begin
                                cur_next  = last_reg;
                                cv_next   = lv_reg;
                                last_next = cur_reg;
                                lv_next   = cv_reg;
                            end
                            skip_next = !skip_reg;
                        end
                    end
                end
                fbsm_pkg::CMD_ILACE:
                begin
                    il_next = req_reg.interlace_on;
                    if (!req_reg.interlace_on)
                    begin
                        pq_next[2] = last_reg;
                        pqv_next   = {1'b0, lv_reg, 2'b00};
                        lv_next    = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (ctl.push)
        begin
            // one return to the free list per cycle; a full list drops it
            pqv_next[sel] = 1'b0;
            if (fc_reg < CNT_W'(NUM_BUFFERS))
            begin
                free_next[fc_reg[IDX_W-1:0]] = push_id;
                fc_next = fc_reg + CNT_W'(1);
            end
            else
            begin
                err_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        out_next.result_id      = res_id_reg;
        out_next.result_valid   = res_v_reg;
        out_next.shown_id       = cv_reg ? cur_reg : '0;
        out_next.shown_valid    = cv_reg;
        out_next.blanked        = blank_reg;
        out_next.blank_is_black = black_reg;
        out_next.error          = err_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUFFERS; i++)
            begin
                free_reg[i] <= ID_W'(i);
            end
            fc_reg    <= CNT_W'(NUM_BUFFERS);
            pc_reg    <= 2'd0;
            cur_reg   <= '0;
            cv_reg    <= 1'b0;
            last_reg  <= '0;
            lv_reg    <= 1'b0;
            blank_reg <= 1'b1;
            black_reg <= 1'b1;
            il_reg    <= 1'b0;
            skip_reg  <= 1'b0;
            err_reg   <= 1'b0;
            pqv_reg   <= '0;
        end
        else
        begin
            free_reg  <= free_next;
            fc_reg    <= fc_next;
            pc_reg    <= pc_next;
            cur_reg   <= cur_next;
            cv_reg    <= cv_next;
            last_reg  <= last_next;
            lv_reg    <= lv_next;
            blank_reg <= blank_next;
            black_reg <= black_next;
            il_reg    <= il_next;
            skip_reg  <= skip_next;
            err_reg   <= err_next;
            pqv_reg   <= pqv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg   <= pend_next;
        pq_reg     <= pq_next;
        res_id_reg <= res_id_next;
        res_v_reg  <= res_v_next;
        if (ctl.load)
        begin
            req_reg <= req_word;
        end
        if (ctl.finish)
        begin
            out_reg <= out_next;
        end
    end

    assign sts.push_busy = (pqv_reg != '0);
    assign rsp_word      = out_reg;

    a_push_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |-> (pqv_reg != '0))
        else $error("push issued with empty push queue");

    a_free_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= CNT_W'(NUM_BUFFERS))
        else $error("free count above pool size");

    a_pend_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= 2'(PD))
        else $error("pending count above queue depth");

    a_blank_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.exec && (cmd == fbsm_pkg::CMD_BLANK))
        |=> (pc_reg == 2'd0) && !cv_reg && !lv_reg && blank_reg)
        else $error("blank left a buffer in use");

endmodule

// ----- design/frame_buffer_swap_manager.sv -----
// Top level: frame buffer swap manager, controller plus datapath behind two handshake channels.
// Each command word on req yields exactly one response word on rsp. A word is accepted,
// executed, then hands back to the free list each buffer the command returns (zero to four),
// and last its response is loaded. The free list takes one returned id per cycle through its
// single write port. A new response is loaded only once the previous one has been taken, so
// a response left waiting on rsp.ready stalls the next word. Blank and an immediate present
// return the most buffers. The block works on one command at a time; req.ready is high
// whenever no command is in progress, even while the previous response still waits in the
// output register for rsp.ready.
// Responses report the id handed out by claim or get-current, the buffer now selected for
// scanout, the blank state and colour, and an error bit for that command alone (empty
// claim, id outside the pool, or a release into a full free list, which drops the id).
module frame_buffer_swap_manager #(
    parameter int NUM_BUFFERS = fbsm_pkg::NUM_BUFFERS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    fbsm_req_if.sink   req,
    fbsm_rsp_if.source rsp
);

    fbsm_pkg::ctl_t      ctl;
    fbsm_pkg::sts_t      sts;
    fbsm_pkg::req_word_t req_word;
    fbsm_pkg::rsp_word_t rsp_word;

    // pack the incoming command word
    assign req_word = '{
        cmd:              req.cmd,
        buffer_id:        req.buffer_id,
        sync:             req.sync,
        release_previous: req.release_previous,
        set_black:        req.set_black,
        interlace_on:     req.interlace_on
    };

    // sequencing: accept, execute, drain returns, load response
    fbsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // buffer bookkeeping and the response register
    fbsm_dp #(
        .NUM_BUFFERS (NUM_BUFFERS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_word (req_word),
        .ctl      (ctl),
        .sts      (sts),
        .rsp_word (rsp_word)
    );

    // unpack the response word
    assign rsp.result_id      = rsp_word.result_id;
    assign rsp.result_valid   = rsp_word.result_valid;
    assign rsp.shown_id       = rsp_word.shown_id;
    assign rsp.shown_valid    = rsp_word.shown_valid;
    assign rsp.blanked        = rsp_word.blanked;
    assign rsp.blank_is_black = rsp_word.blank_is_black;
    assign rsp.error          = rsp_word.error;

endmodule

// ----- sim/testbench.sv -----
// Testbench: randomized and directed checking of the frame buffer swap manager against a local model.
module testbench;

    localparam int ID_W        = fbsm_pkg::ID_W;
    localparam int CMD_W       = fbsm_pkg::CMD_W;
    localparam int PEND_DEPTH  = fbsm_pkg::PEND_DEPTH;
    localparam int POOL        = fbsm_pkg::NUM_BUFFERS_DEF;
    localparam int LONG_HOLD   = 60;    // response-side hold-off used to back up the block
    localparam int STALL_LIMIT = 2000;  // cycles with no word moving on either channel
    localparam int RANDOM_SEGS = 17;    // random words go out in segments of 100
    localparam int MAX_PRINTS  = 40;

    // Codes 6 and 7 are unused by the block: it only reports its status.
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    logic clk = 1'b0;
    logic rst_n;

    fbsm_req_if req_ch ();
    fbsm_rsp_if rsp_ch ();

    frame_buffer_swap_manager dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Buffer bookkeeping mirrored from the block's behavior.
    // free_q/free_n    : free list, head at index 0
    // pend_q/pend_n    : up to two buffers waiting for vsync
    // cur_*            : buffer in scanout
    // prev_*           : other field's buffer in interlace mode
    // ------------------------------------------------------------------
    logic [ID_W-1:0] free_q [POOL];
    int              free_n;
    logic [ID_W-1:0] pend_q [PEND_DEPTH];
    int              pend_n;
    logic [ID_W-1:0] cur_id;
    bit              cur_ok;
    logic [ID_W-1:0] prev_id;
    bit              prev_ok;
    bit              blank_on;
    bit              blank_blk;
    bit              ilace_on;
    bit              skip_ph;
    bit              step_err;

    fbsm_pkg::rsp_word_t status_due [$];   // predicted status words, oldest first
    int        fail_count   = 0;
    int        rsp_count    = 0;
    int        still_cycles = 0;
    bit        calm;             // no idling on either side while set
    bit        hold_request;     // asks the response side for one long hold-off

    // A returned id goes to the tail of the free list; a full list drops it and flags error.
    function automatic void give_back(logic [ID_W-1:0] id);
        if (free_n < POOL) begin
            free_q[free_n] = id;
            free_n++;
        end else begin
            step_err = 1'b1;
        end
    endfunction

    // Current stays "valid" here; callers decide what replaces it.
    function automatic void drop_current();
        if (cur_ok)
            give_back(cur_id);
    endfunction

    function automatic void drop_field();
        if (prev_ok) begin
            give_back(prev_id);
            prev_ok = 1'b0;
        end
    endfunction

    function automatic void flush_queue();
        for (int i = 0; i < pend_n && i < PEND_DEPTH; i++)
            give_back(pend_q[i]);
        pend_n = 0;
    endfunction

    function automatic void advance_queue();
        cur_id    = pend_q[0];
        cur_ok    = 1'b1;
        pend_q[0] = pend_q[1];
        pend_n--;
    endfunction

    // Swap happens only with a valid other field; valid bits travel with the ids.
    function automatic void swap_fields();
        logic [ID_W-1:0] t;
        bit              tv;
        if (prev_ok) begin
            t       = cur_id;
            tv      = cur_ok;
            cur_id  = prev_id;
            cur_ok  = prev_ok;
            prev_id = t;
            prev_ok = tv;
        end
    endfunction

    // Apply one accepted command to the mirrored state and return the status word it yields.
    function automatic fbsm_pkg::rsp_word_t predict_status(fbsm_pkg::req_word_t w);
        fbsm_pkg::rsp_word_t r;
        logic [ID_W-1:0]     rid;
        bit                  rok;
        logic [ID_W-1:0]     old_id;
        bit                  old_ok;
        rid      = '0;
        rok      = 1'b0;
        step_err = 1'b0;
        case (w.cmd)
            fbsm_pkg::CMD_CLAIM: begin
                // free list first, then the other field, then the buffer on screen
                if (free_n > 0) begin
                    rid = free_q[0];
                    rok = 1'b1;
                    free_n--;
                    for (int i = 0; i + 1 < POOL; i++)
                        free_q[i] = free_q[i + 1];
                end else if (prev_ok) begin
                    rid     = prev_id;
                    rok     = 1'b1;
                    prev_ok = 1'b0;
                end else if (cur_ok) begin
                    rid = cur_id;
                    rok = 1'b1;
                    if (pend_n > 0)
                        advance_queue();
                    else
                        cur_ok = 1'b0;
                end else begin
                    step_err = 1'b1;
                end
            end
            fbsm_pkg::CMD_PRESENT: begin
                if (w.buffer_id >= POOL) begin
                    step_err = 1'b1;
                end else if (w.sync && !blank_on) begin
                    if (pend_n < PEND_DEPTH) begin
                        pend_q[pend_n] = w.buffer_id;
                        pend_n++;
                    end else if (ilace_on) begin
                        give_back(pend_q[0]);
                        give_back(pend_q[1]);
                        pend_q[0] = w.buffer_id;
                        pend_n    = 1;
                    end else begin
                        // queue full: the oldest waiting buffer is dropped back
                        give_back(pend_q[0]);
                        pend_q[0] = pend_q[1];
                        pend_q[1] = w.buffer_id;
                    end
                end else begin
                    old_id = cur_id;
                    old_ok = cur_ok;
                    flush_queue();
                    drop_field();
                    cur_id = w.buffer_id;
                    cur_ok = 1'b1;
                    if (old_ok && w.release_previous)
                        give_back(old_id);
                    blank_on = 1'b0;
                end
            end
            fbsm_pkg::CMD_GET: begin
                // newest waiting buffer jumps to the screen, the rest go back
                if (pend_n > 0) begin
                    drop_current();
                    cur_id = pend_q[(pend_n - 1) & 1];
                    cur_ok = 1'b1;
                    pend_n--;
                    flush_queue();
                end
                rid = cur_id;
                rok = cur_ok;
            end
            fbsm_pkg::CMD_BLANK: begin
                blank_on  = 1'b1;
                blank_blk = w.set_black;
                flush_queue();
                drop_field();
                drop_current();
                cur_ok = 1'b0;
            end
            fbsm_pkg::CMD_VSYNC: begin
                if (!blank_on) begin
                    if (pend_n > 0) begin
                        if (!ilace_on) begin
                            drop_current();
                            advance_queue();
                        end else if (skip_ph) begin
                            if (prev_ok)
                                give_back(prev_id);
                            if (pend_n >= PEND_DEPTH) begin
                                prev_ok = 1'b0;
                                drop_current();
                            end else begin
                                prev_id = cur_id;
                                prev_ok = cur_ok;
                            end
                            advance_queue();
                        end else begin
                            if (pend_n >= PEND_DEPTH) begin
                                drop_field();
                                drop_current();
                                cur_id  = pend_q[1];
                                cur_ok  = 1'b1;
                                prev_id = pend_q[0];
                                prev_ok = 1'b1;
                                pend_n  = 0;
                            end else begin
                                swap_fields();
                            end
                            skip_ph = !skip_ph;
                        end
                    end else if (ilace_on) begin
                        swap_fields();
                        skip_ph = !skip_ph;
                    end
                end
            end
            fbsm_pkg::CMD_ILACE: begin
                ilace_on = w.interlace_on;
                if (!w.interlace_on)
                    drop_field();
            end
            default: ;
        endcase
        r.result_id      = rok ? rid : '0;
        r.result_valid   = rok;
        r.shown_id       = cur_ok ? cur_id : '0;
        r.shown_valid    = cur_ok;
        r.blanked        = blank_on;
        r.blank_is_black = blank_blk;
        r.error          = step_err;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting; printing stops after a few dozen lines.
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        fail_count++;
        if (fail_count <= MAX_PRINTS)
            $display("mismatch: %s on response %0d, got %0d, want %0d",
                     what, rsp_count, got, want);
    endtask

    // Mostly short gaps, some medium, a few long.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(15, 40);
    endfunction

    function automatic fbsm_pkg::req_word_t word_of(logic [CMD_W-1:0] cmd,
                                                    logic [ID_W-1:0] id, bit sync, bit rel,
                                                    bit black, bit il);
        fbsm_pkg::req_word_t w;
        w.cmd              = cmd;
        w.buffer_id        = id;
        w.sync             = sync;
        w.release_previous = rel;
        w.set_black        = black;
        w.interlace_on     = il;
        return w;
    endfunction

    // Weighted command mix; presents lean toward sync so the vsync queue fills up.
    function automatic fbsm_pkg::req_word_t random_word();
        fbsm_pkg::req_word_t w;
        int                  pick;
        w = word_of(fbsm_pkg::CMD_CLAIM, 2'($urandom_range(0, 3)),
                    ($urandom_range(0, 3) != 0),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        pick = $urandom_range(0, 99);
        if (pick < 18)
            w.cmd = fbsm_pkg::CMD_CLAIM;
        else if (pick < 48)
            w.cmd = fbsm_pkg::CMD_PRESENT;
        else if (pick < 58)
            w.cmd = fbsm_pkg::CMD_GET;
        else if (pick < 62)
            w.cmd = fbsm_pkg::CMD_BLANK;
        else if (pick < 88)
            w.cmd = fbsm_pkg::CMD_VSYNC;
        else if (pick < 96)
            w.cmd = fbsm_pkg::CMD_ILACE;
        else
            w.cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Command side. Entered and left at a falling edge. valid is only
    // lowered when a gap is taken, so a back-to-back word never sees
    // valid dropped and raised in the same step. The prediction is made
    // at the edge that accepts the word, so state follows accept order.
    // ------------------------------------------------------------------
    task automatic send_word(fbsm_pkg::req_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.cmd              <= w.cmd;
        req_ch.buffer_id        <= w.buffer_id;
        req_ch.sync             <= w.sync;
        req_ch.release_previous <= w.release_previous;
        req_ch.set_black        <= w.set_black;
        req_ch.interlace_on     <= w.interlace_on;
        req_ch.valid            <= 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        status_due.push_back(predict_status(w));
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Response side: ready changes at the falling edge only. The first
    // time hold_request is seen it turns into one long hold-off counted here.
    // ------------------------------------------------------------------
    initial
    begin : response_side
        int quiet;
        bit held;
        quiet        = 0;
        held         = 1'b0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request && !held)
            begin
                held  = 1'b1;
                quiet = LONG_HOLD;
            end
            else if (quiet == 0 && $urandom_range(0, 99) < 25)
            begin
                quiet = pick_gap();
            end
            if (quiet > 0)
            begin
                rsp_ch.ready <= 1'b0;
                quiet--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Every accepted status word is checked field by field against the oldest prediction.
    always @(posedge clk)
    begin : status_check
        fbsm_pkg::rsp_word_t got;
        fbsm_pkg::rsp_word_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.result_id      = rsp_ch.result_id;
            got.result_valid   = rsp_ch.result_valid;
            got.shown_id       = rsp_ch.shown_id;
            got.shown_valid    = rsp_ch.shown_valid;
            got.blanked        = rsp_ch.blanked;
            got.blank_is_black = rsp_ch.blank_is_black;
            got.error          = rsp_ch.error;
            if (status_due.size() == 0)
            begin
                report_mismatch("response with no command outstanding", 1, 0);
            end
            else
            begin
                want = status_due.pop_front();
                if (got.result_id !== want.result_id)
                    report_mismatch("result_id", got.result_id, want.result_id);
                if (got.result_valid !== want.result_valid)
                    report_mismatch("result_valid", got.result_valid, want.result_valid);
                if (got.shown_id !== want.shown_id)
                    report_mismatch("shown_id", got.shown_id, want.shown_id);
                if (got.shown_valid !== want.shown_valid)
                    report_mismatch("shown_valid", got.shown_valid, want.shown_valid);
                if (got.blanked !== want.blanked)
                    report_mismatch("blanked", got.blanked, want.blanked);
                if (got.blank_is_black !== want.blank_is_black)
                    report_mismatch("blank_is_black", got.blank_is_black, want.blank_is_black);
                if (got.error !== want.error)
                    report_mismatch("error", got.error, want.error);
            end
            rsp_count++;
        end
    end

    // Watchdog: any word moving on either channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            still_cycles <= 0;
        else
            still_cycles <= still_cycles + 1;
        if (still_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Walk through the corner cases by hand, starting from reset.
    task automatic test_directed();
        send_word(word_of(fbsm_pkg::CMD_GET,     2'd0, 0, 0, 0, 0)); // nothing on screen yet
        send_word(word_of(fbsm_pkg::CMD_VSYNC,   2'd3, 1, 1, 1, 1)); // ignored while blanked
        send_word(word_of(CMD_SPARE_A,           2'd1, 1, 0, 1, 0)); // unused codes only report
        send_word(word_of(CMD_SPARE_B,           2'd2, 0, 1, 0, 1));
        send_word(word_of(fbsm_pkg::CMD_PRESENT, 2'd0, 0, 1, 0, 0)); // no valid current to release
        send_word(word_of(fbsm_pkg::CMD_BLANK,   2'd0, 0, 0, 0, 0)); // white; release into full list
        repeat (4)
            send_word(word_of(fbsm_pkg::CMD_CLAIM, 2'd0, 0, 0, 0, 0));
        send_word(word_of(fbsm_pkg::CMD_CLAIM,   2'd0, 0, 0, 0, 0)); // nothing left anywhere
        send_word(word_of(fbsm_pkg::CMD_PRESENT, 2'd1, 1, 0, 0, 0)); // sync while blanked: shows now
        send_word(word_of(fbsm_pkg::CMD_CLAIM,   2'd0, 0, 0, 0, 0)); // steals current, queue empty
        send_word(word_of(fbsm_pkg::CMD_PRESENT, 2'd2, 0, 1, 0, 0));
        send_word(word_of(fbsm_pkg::CMD_PRESENT, 2'd3, 1, 0, 0, 0));
        send_word(word_of(fbsm_pkg::CMD_PRESENT, 2'd0, 1, 0, 0, 0));
        send_word(word_of(fbsm_pkg::CMD_PRESENT, 2'd1, 1, 0, 0, 0)); // queue full: oldest dropped
        send_word(word_of(fbsm_pkg::CMD_GET,     2'd0, 0, 0, 0, 0)); // newest waiting buffer shown
        send_word(word_of(fbsm_pkg::CMD_ILACE,   2'd0, 0, 0, 0, 1));
        send_word(word_of(fbsm_pkg::CMD_PRESENT, 2'd2, 1, 0, 0, 0));
        send_word(word_of(fbsm_pkg::CMD_PRESENT, 2'd3, 1, 0, 0, 0));
        send_word(word_of(fbsm_pkg::CMD_VSYNC,   2'd0, 0, 0, 0, 0)); // both fields from the queue
        send_word(word_of(fbsm_pkg::CMD_VSYNC,   2'd0, 0, 0, 0, 0)); // field swap, nothing waiting
        send_word(word_of(fbsm_pkg::CMD_ILACE,   2'd0, 0, 0, 0, 0)); // leaving interlace frees last
        send_word(word_of(fbsm_pkg::CMD_BLANK,   2'd3, 1, 1, 1, 1)); // black
    endtask

    // Response side stalls for a long stretch while commands keep coming back to back.
    task automatic test_backpressure();
        calm         = 1'b1;
        hold_request = 1'b1;
        repeat (24)
            send_word(random_word());
        hold_request = 1'b0;
        calm         = 1'b0;
    endtask

    // Bulk random traffic; every fourth segment runs without idling on either side.
    task automatic test_random();
        for (int seg = 0; seg < RANDOM_SEGS; seg++)
        begin
            calm = (seg % 4 == 3);
            repeat (100)
                send_word(random_word());
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                   <= 1'b0;
        req_ch.valid            <= 1'b0;
        req_ch.cmd              <= fbsm_pkg::CMD_CLAIM;
        req_ch.buffer_id        <= '0;
        req_ch.sync             <= 1'b0;
        req_ch.release_previous <= 1'b0;
        req_ch.set_black        <= 1'b0;
        req_ch.interlace_on     <= 1'b0;
        calm                    = 1'b0;
        hold_request            = 1'b0;

        // power-on view of the buffers: all free in id order, display blanked black
        for (int i = 0; i < POOL; i++)
            free_q[i] = i[ID_W-1:0];
        free_n    = POOL;
        pend_q[0] = '0;
        pend_q[1] = '0;
        pend_n    = 0;
        cur_id    = '0;
        cur_ok    = 1'b0;
        prev_id   = '0;
        prev_ok   = 1'b0;
        blank_on  = 1'b1;
        blank_blk = 1'b1;
        ilace_on  = 1'b0;
        skip_ph   = 1'b0;
        step_err  = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_random();

        // send_word leaves us at a falling edge
        req_ch.valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        // then idle on, to catch stray responses
        repeat (30) @(posedge clk);

        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
